// ----- sv/skct_pkg.sv -----
// Shared types and constants for the sorted key/child table.
`timescale 1ns / 1ps

package skct_pkg;

  // Fixed field widths of the item and result channels
  localparam int KEY_W   = 8;
  localparam int CHILD_W = 64;
  localparam int POS_W   = 4;
  localparam int CNT_W   = 5;
  localparam int ACT_W   = 3;
  localparam int ERR_W   = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOOKUP   = 3'd0,
    ACT_INSERT   = 3'd1,
    ACT_REMOVE   = 3'd2,
    ACT_CHANGE   = 3'd3,
    ACT_SEEK     = 3'd4,
    ACT_READ_POS = 3'd5,
    ACT_RANGE    = 3'd6
  } action_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE      = 2'd0,
    ERR_NOT_FOUND = 2'd1,
    ERR_FULL      = 2'd2
  } err_t;

  // What a cell does with its entry at the next edge
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT_UP,
    CELL_SHIFT_DN,
    CELL_CHILD
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RANGE
  } state_t;

  // Compare results of one cell against the current item
  typedef struct packed {
    logic eq;
    logic gt;
    logic ge;
    logic eq_end;
  } cell_flags_t;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [KEY_W-1:0]   key;
    logic [KEY_W-1:0]   key_end;
    logic [CHILD_W-1:0] child_in;
    logic [POS_W-1:0]   position;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [KEY_W-1:0]   key_out;
    logic [CHILD_W-1:0] child_out;
    logic [POS_W-1:0]   entry_pos;
    logic [CNT_W-1:0]   entry_count;
    logic               is_full;
    logic               is_underfull;
    logic [ERR_W-1:0]   error_code;
    logic               last;
  } out_item_t;

endpackage

// ----- sv/skct_cell.sv -----
// One table cell: holds one key/child entry and trades it with its neighbors.
`timescale 1ns / 1ps

module skct_cell #(
  parameter int CHILD_WIDTH = 64
) (
  input  logic                           clk,
  input  skct_pkg::cell_op_t             cell_op,
  input  logic                           occupied,
  input  logic [skct_pkg::KEY_W-1:0]     item_key,
  input  logic [skct_pkg::KEY_W-1:0]     item_key_end,
  input  logic [CHILD_WIDTH-1:0]         item_child,
  input  logic [skct_pkg::KEY_W-1:0]     up_key,
  input  logic [CHILD_WIDTH-1:0]         up_child,
  input  logic [skct_pkg::KEY_W-1:0]     dn_key,
  input  logic [CHILD_WIDTH-1:0]         dn_child,
  output logic [skct_pkg::KEY_W-1:0]     key_r,
  output logic [CHILD_WIDTH-1:0]         child_r,
  output skct_pkg::cell_flags_t          flags
);

  // Entry storage; up is the lower neighbor, dn the upper one
  always_ff @(posedge clk) begin
    case (cell_op)
      skct_pkg::CELL_LOAD: begin
        key_r   <= item_key;
        child_r <= item_child;
      end
      skct_pkg::CELL_SHIFT_UP: begin
        key_r   <= up_key;
        child_r <= up_child;
      end
      skct_pkg::CELL_SHIFT_DN: begin
        key_r   <= dn_key;
        child_r <= dn_child;
      end
      skct_pkg::CELL_CHILD: begin
        child_r <= item_child;
      end
      default: begin
      end
    endcase
  end

  // Local compares; an empty cell never matches
  always_comb begin
    flags.eq     = occupied && (key_r == item_key);
    flags.gt     = occupied && (key_r > item_key);
    flags.ge     = occupied && (key_r >= item_key);
    flags.eq_end = occupied && (key_r == item_key_end);
  end

endmodule

// ----- sv/sorted_key_child_table16.sv -----
// Top level of the sorted key/child table: cell row, control and result register.
`timescale 1ns / 1ps
//
// Sorted table of up to CAPACITY entries (8-bit key, child word), kept in
// ascending unsigned key order in a row of cells that shift entries up or
// down to open or close a gap.
// Input channel in_valid/in_stall/in_data carries one action per item;
// result channel out_valid/out_stall/out_data returns the results.
// An accepted item is registered in the item register; in the execute state
// the compares run in every cell, the target entry is picked and the shift
// or write is applied as the result is loaded into the output register.
// Single-entry actions: one result; the next item is taken only after the item
// register and the compare/update pass over the cell row.
// Range read: after a setup pass that finds the bounds, n entries come out one
// per cycle while the result side does not stall.
// in_stall is high while an item is being worked on.
// A stalled result holds in the output register; a range read waits on it.
// Reset empties the table (entry count zero); cell contents are not cleared,
// and only entries below the count are ever read.
//
module sorted_key_child_table16 #(
  parameter int CAPACITY     = 16,
  parameter int CHILD_WIDTH  = 64,
  parameter int UNDERFULL_AT = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  skct_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output skct_pkg::out_item_t out_data
);

  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int POS_IN_W    = skct_pkg::POS_W;
  localparam int PCMP_W      = (CNT_W > POS_IN_W) ? CNT_W : POS_IN_W;
  localparam int OUT_CHILD_W = skct_pkg::CHILD_W;
  localparam int OUT_CNT_W   = skct_pkg::CNT_W;
  localparam int KEY_W       = skct_pkg::KEY_W;

  skct_pkg::state_t    state_r, state_nxt;
  skct_pkg::in_item_t  item_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [IDX_W-1:0]    cursor_r, cursor_nxt;
  logic [IDX_W-1:0]    end_r, end_nxt;
  logic                out_valid_r;
  skct_pkg::out_item_t out_data_r;

  logic [KEY_W-1:0]       cell_key   [CAPACITY];
  logic [CHILD_WIDTH-1:0] cell_child [CAPACITY];
  skct_pkg::cell_flags_t  cell_flags [CAPACITY];
  skct_pkg::cell_op_t     cell_op    [CAPACITY];
  logic [CAPACITY-1:0]    occ;

  logic [CAPACITY-1:0] eq_vec, gt_vec, ge_vec, eqe_vec;
  logic [CAPACITY-1:0] first_eq, first_gt, first_ge, first_eqe;
  logic [CAPACITY-1:0] count_dec, pos_dec, cursor_dec, sel;
  logic                eq_any, gt_any, ge_any, eqe_any;
  logic [IDX_W-1:0]    eq_idx, gt_idx, ge_idx, eqe_idx;
  logic [KEY_W-1:0]       sel_key;
  logic [CHILD_WIDTH-1:0] sel_child;
  logic [CHILD_WIDTH-1:0] item_child;
  logic                   can_load, out_load, pos_ok;
  skct_pkg::out_item_t    result;

  function automatic logic [IDX_W-1:0] enc_onehot(input logic [CAPACITY-1:0] oh);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (oh[i]) idx = idx | IDX_W'(i);
    end
    return idx;
  endfunction

  assign item_child = item_r.child_in[CHILD_WIDTH-1:0];

  // Cell row
  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [KEY_W-1:0]       up_key, dn_key;
      logic [CHILD_WIDTH-1:0] up_child, dn_child;
      if (g == 0) begin : g_lo
        assign up_key   = cell_key[g];
        assign up_child = cell_child[g];
      end else begin : g_lo
        assign up_key   = cell_key[g-1];
        assign up_child = cell_child[g-1];
      end
      if (g == CAPACITY - 1) begin : g_hi
        assign dn_key   = cell_key[g];
        assign dn_child = cell_child[g];
      end else begin : g_hi
        assign dn_key   = cell_key[g+1];
        assign dn_child = cell_child[g+1];
      end
      skct_cell #(
        .CHILD_WIDTH (CHILD_WIDTH)
      ) u_cell (
        .clk          (clk),
        .cell_op      (cell_op[g]),
        .occupied     (occ[g]),
        .item_key     (item_r.key),
        .item_key_end (item_r.key_end),
        .item_child   (item_child),
        .up_key       (up_key),
        .up_child     (up_child),
        .dn_key       (dn_key),
        .dn_child     (dn_child),
        .key_r        (cell_key[g]),
        .child_r      (cell_child[g]),
        .flags        (cell_flags[g])
      );
    end
  endgenerate

  // Occupancy, flag vectors and decodes
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occ[i]        = (CNT_W'(i) < count_r);
      eq_vec[i]     = cell_flags[i].eq;
      gt_vec[i]     = cell_flags[i].gt;
      ge_vec[i]     = cell_flags[i].ge;
      eqe_vec[i]    = cell_flags[i].eq_end;
      count_dec[i]  = (CNT_W'(i) == count_r);
      pos_dec[i]    = (PCMP_W'(i) == PCMP_W'(item_r.position));
      cursor_dec[i] = (IDX_W'(i) == cursor_r);
    end
  end

  // Keys are sorted, so each match set is contiguous: first = lowest bit
  assign first_eq  = eq_vec  & ~{eq_vec[CAPACITY-2:0],  1'b0};
  assign first_gt  = gt_vec  & ~{gt_vec[CAPACITY-2:0],  1'b0};
  assign first_ge  = ge_vec  & ~{ge_vec[CAPACITY-2:0],  1'b0};
  assign first_eqe = eqe_vec & ~{eqe_vec[CAPACITY-2:0], 1'b0};
  assign eq_any    = |eq_vec;
  assign gt_any    = |gt_vec;
  assign ge_any    = |ge_vec;
  assign eqe_any   = |eqe_vec;
  assign eq_idx    = enc_onehot(first_eq);
  assign gt_idx    = enc_onehot(first_gt);
  assign ge_idx    = enc_onehot(first_ge);
  assign eqe_idx   = enc_onehot(first_eqe);
  assign pos_ok    = PCMP_W'(item_r.position) < PCMP_W'(count_r);

  // Entry select for the read path
  always_comb begin
    sel = '0;
    if (state_r == skct_pkg::ST_RANGE) begin
      sel = cursor_dec;
    end else begin
      case (skct_pkg::action_t'(item_r.action))
        skct_pkg::ACT_SEEK:     sel = first_ge;
        skct_pkg::ACT_READ_POS: sel = pos_dec;
        default:                sel = first_eq;
      endcase
    end
  end

  always_comb begin
    sel_key   = '0;
    sel_child = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (sel[i]) begin
        sel_key   = sel_key | cell_key[i];
        sel_child = sel_child | cell_child[i];
      end
    end
  end

  assign can_load = !out_valid_r || !out_stall;

  // Control: action decode, cell ops and result build
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    end_nxt    = end_r;
    out_load   = 1'b0;
    result     = '0;
    result.last       = 1'b1;
    result.error_code = skct_pkg::ERR_NONE;
    for (int i = 0; i < CAPACITY; i++) cell_op[i] = skct_pkg::CELL_HOLD;

    case (state_r)
      skct_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = skct_pkg::ST_EXEC;
      end
      skct_pkg::ST_EXEC: begin
        if (can_load) begin
          out_load  = 1'b1;
          state_nxt = skct_pkg::ST_IDLE;
          case (skct_pkg::action_t'(item_r.action))
            skct_pkg::ACT_LOOKUP, skct_pkg::ACT_CHANGE: begin
              if (eq_any) begin
                result.found     = 1'b1;
                result.key_out   = item_r.key;
                result.entry_pos = POS_IN_W'(eq_idx);
                if (skct_pkg::action_t'(item_r.action) == skct_pkg::ACT_CHANGE) begin
                  result.child_out = OUT_CHILD_W'(item_child);
                  for (int i = 0; i < CAPACITY; i++) begin
                    if (first_eq[i]) cell_op[i] = skct_pkg::CELL_CHILD;
                  end
                end else begin
                  result.child_out = OUT_CHILD_W'(sel_child);
                end
              end else begin
                result.error_code = skct_pkg::ERR_NOT_FOUND;
              end
            end
            skct_pkg::ACT_INSERT: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                result.error_code = skct_pkg::ERR_FULL;
              end else begin
                // New entry lands before the first greater key, else at the end
                for (int i = 0; i < CAPACITY; i++) begin
                  if (gt_any ? first_gt[i] : count_dec[i]) begin
                    cell_op[i] = skct_pkg::CELL_LOAD;
                  end else if (i > 0) begin
                    if (gt_vec[i-1]) cell_op[i] = skct_pkg::CELL_SHIFT_UP;
                  end
                end
                count_nxt        = count_r + CNT_W'(1);
                result.found     = 1'b1;
                result.key_out   = item_r.key;
                result.child_out = OUT_CHILD_W'(item_child);
                result.entry_pos = POS_IN_W'(gt_any ? gt_idx : count_r[IDX_W-1:0]);
              end
            end
            skct_pkg::ACT_REMOVE: begin
              if (eq_any) begin
                // Entries from the match upward move down one place
                for (int i = 0; i < CAPACITY - 1; i++) begin
                  if (ge_vec[i]) cell_op[i] = skct_pkg::CELL_SHIFT_DN;
                end
                count_nxt        = count_r - CNT_W'(1);
                result.found     = 1'b1;
                result.key_out   = item_r.key;
                result.child_out = OUT_CHILD_W'(sel_child);
                result.entry_pos = POS_IN_W'(eq_idx);
              end else begin
                result.error_code = skct_pkg::ERR_NOT_FOUND;
              end
            end
            skct_pkg::ACT_SEEK: begin
              if (ge_any) begin
                result.found     = 1'b1;
                result.key_out   = sel_key;
                result.child_out = OUT_CHILD_W'(sel_child);
                result.entry_pos = POS_IN_W'(ge_idx);
              end else begin
                result.error_code = skct_pkg::ERR_NOT_FOUND;
              end
            end
            skct_pkg::ACT_READ_POS: begin
              if (pos_ok) begin
                result.found     = 1'b1;
                result.key_out   = sel_key;
                result.child_out = OUT_CHILD_W'(sel_child);
                result.entry_pos = item_r.position;
              end else begin
                result.error_code = skct_pkg::ERR_NOT_FOUND;
              end
            end
            skct_pkg::ACT_RANGE: begin
              // Bounds: start at first equal key or 0, end at first equal or last
              cursor_nxt = eq_any ? eq_idx : '0;
              end_nxt    = eqe_any ? eqe_idx : IDX_W'(count_r - CNT_W'(1));
              if (count_r == '0 || cursor_nxt > end_nxt) begin
                result.error_code = skct_pkg::ERR_NOT_FOUND;
              end else begin
                out_load  = 1'b0;
                state_nxt = skct_pkg::ST_RANGE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      skct_pkg::ST_RANGE: begin
        if (can_load) begin
          out_load         = 1'b1;
          result.found     = 1'b1;
          result.key_out   = sel_key;
          result.child_out = OUT_CHILD_W'(sel_child);
          result.entry_pos = POS_IN_W'(cursor_r);
          result.last      = (cursor_r == end_r);
          if (cursor_r == end_r) begin
            state_nxt = skct_pkg::ST_IDLE;
          end else begin
            cursor_nxt = cursor_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = skct_pkg::ST_IDLE;
      end
    endcase

    result.entry_count  = OUT_CNT_W'(count_nxt);
    result.is_full      = (count_nxt == CNT_W'(CAPACITY));
    result.is_underfull = (32'(count_nxt) == 32'(UNDERFULL_AT));
  end

  // State and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= skct_pkg::ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Item register and range bounds
  always_ff @(posedge clk) begin
    if (state_r == skct_pkg::ST_IDLE && in_valid) item_r <= in_data;
    cursor_r <= cursor_nxt;
    end_r    <= end_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= result;
  end

  assign in_stall  = (state_r != skct_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == skct_pkg::ST_EXEC))
    else $error("accepted item not executed");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count_r) |-> (count_r == $past(count_r) + CNT_W'(1) ||
                           count_r == $past(count_r) - CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_range_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == skct_pkg::ST_RANGE) |-> (cursor_r <= end_r))
    else $error("range cursor passed end");

  a_mid_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !result.last) |=> (state_r == skct_pkg::ST_RANGE))
    else $error("non-final result outside range read");

endmodule

// ----- test/table16_check_pkg.sv -----
// Scoreboard for the sorted key/child table: table predictor and result check.
`timescale 1ns / 1ps

package table16_check_pkg;
  import skct_pkg::*;

  localparam int TABLE_DEPTH   = 16;
  localparam int UNDERFULL_LVL = 3;

  class table16_scoreboard;
    logic [KEY_W-1:0]   key_tab[TABLE_DEPTH];
    logic [CHILD_W-1:0] child_tab[TABLE_DEPTH];
    int unsigned        n_entries;
    out_item_t          result_q[$];
    int unsigned        fail_count;

    function new();
      n_entries  = 0;
      fail_count = 0;
    endfunction

    function int unsigned pending();
      return result_q.size();
    endfunction

    // first slot holding k, or n_entries when absent
    function int unsigned find_key(logic [KEY_W-1:0] k);
      for (int unsigned i = 0; i < n_entries; i++)
        if (key_tab[i] == k) return i;
      return n_entries;
    endfunction

    // flags are taken from the table after the action
    function void push_result(bit hit, logic [KEY_W-1:0] k, logic [CHILD_W-1:0] c,
                              int unsigned pos, err_t err, bit fin);
      out_item_t r;
      r.found        = hit;
      r.key_out      = k;
      r.child_out    = c;
      r.entry_pos    = pos[POS_W-1:0];
      r.entry_count  = n_entries[CNT_W-1:0];
      r.is_full      = (n_entries == TABLE_DEPTH);
      r.is_underfull = (n_entries == UNDERFULL_LVL);
      r.error_code   = err;
      r.last         = fin;
      result_q.push_back(r);
    endfunction

    // apply one accepted item to the table and queue its results
    function void note_item(in_item_t it);
      int unsigned        slot;
      int unsigned        stop;
      logic [CHILD_W-1:0] old_child;
      case (it.action)
        ACT_LOOKUP, ACT_CHANGE: begin
          slot = find_key(it.key);
          if (slot >= n_entries) begin
            push_result(1'b0, '0, '0, 0, ERR_NOT_FOUND, 1'b1);
          end else begin
            if (it.action == ACT_CHANGE) child_tab[slot] = it.child_in;
            push_result(1'b1, key_tab[slot], child_tab[slot], slot, ERR_NONE, 1'b1);
          end
        end
        ACT_INSERT: begin
          if (n_entries >= TABLE_DEPTH) begin
            push_result(1'b0, '0, '0, 0, ERR_FULL, 1'b1);
          end else begin
            // new key lands after any equal keys
            slot = n_entries;
            for (int unsigned i = 0; i < n_entries; i++)
              if (slot == n_entries && it.key < key_tab[i]) slot = i;
            for (int unsigned i = n_entries; i > slot; i--) begin
              key_tab[i]   = key_tab[i-1];
              child_tab[i] = child_tab[i-1];
            end
            key_tab[slot]   = it.key;
            child_tab[slot] = it.child_in;
            n_entries++;
            push_result(1'b1, it.key, it.child_in, slot, ERR_NONE, 1'b1);
          end
        end
        ACT_REMOVE: begin
          slot = find_key(it.key);
          if (slot >= n_entries) begin
            push_result(1'b0, '0, '0, 0, ERR_NOT_FOUND, 1'b1);
          end else begin
            old_child = child_tab[slot];
            for (int unsigned i = slot; i + 1 < n_entries; i++) begin
              key_tab[i]   = key_tab[i+1];
              child_tab[i] = child_tab[i+1];
            end
            n_entries--;
            push_result(1'b1, it.key, old_child, slot, ERR_NONE, 1'b1);
          end
        end
        ACT_SEEK: begin
          slot = n_entries;
          for (int unsigned i = 0; i < n_entries; i++)
            if (slot == n_entries && key_tab[i] >= it.key) slot = i;
          if (slot < n_entries)
            push_result(1'b1, key_tab[slot], child_tab[slot], slot, ERR_NONE, 1'b1);
          else
            push_result(1'b0, '0, '0, 0, ERR_NOT_FOUND, 1'b1);
        end
        ACT_READ_POS: begin
          if (32'(it.position) < n_entries)
            push_result(1'b1, key_tab[it.position], child_tab[it.position],
                        32'(it.position), ERR_NONE, 1'b1);
          else
            push_result(1'b0, '0, '0, 0, ERR_NOT_FOUND, 1'b1);
        end
        ACT_RANGE: begin
          if (n_entries == 0) begin
            push_result(1'b0, '0, '0, 0, ERR_NOT_FOUND, 1'b1);
          end else begin
            // absent start key means slot 0, absent end key means the last slot
            slot = find_key(it.key);
            if (slot >= n_entries) slot = 0;
            stop = find_key(it.key_end);
            if (stop >= n_entries) stop = n_entries - 1;
            if (slot > stop) begin
              push_result(1'b0, '0, '0, 0, ERR_NOT_FOUND, 1'b1);
            end else begin
              for (int unsigned i = slot; i <= stop; i++)
                push_result(1'b1, key_tab[i], child_tab[i], i, ERR_NONE, i == stop);
            end
          end
        end
        default: begin
          push_result(1'b0, '0, '0, 0, ERR_NONE, 1'b1);
        end
      endcase
    endfunction

    function void field_check(string name, logic [CHILD_W-1:0] want,
                              logic [CHILD_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        fail_count++;
      end
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(out_item_t got);
      out_item_t want;
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, got);
        fail_count++;
        return;
      end
      want = result_q.pop_front();
      field_check("found", CHILD_W'(want.found), CHILD_W'(got.found));
      field_check("key_out", CHILD_W'(want.key_out), CHILD_W'(got.key_out));
      field_check("child_out", want.child_out, got.child_out);
      field_check("entry_pos", CHILD_W'(want.entry_pos), CHILD_W'(got.entry_pos));
      field_check("entry_count", CHILD_W'(want.entry_count), CHILD_W'(got.entry_count));
      field_check("is_full", CHILD_W'(want.is_full), CHILD_W'(got.is_full));
      field_check("is_underfull", CHILD_W'(want.is_underfull), CHILD_W'(got.is_underfull));
      field_check("error_code", CHILD_W'(want.error_code), CHILD_W'(got.error_code));
      field_check("last", CHILD_W'(want.last), CHILD_W'(got.last));
    endfunction
  endclass

endpackage

// ----- test/tb_sorted_key_child_table16.sv -----
// Testbench top for the sorted key/child table: directed and random actions.
`timescale 1ns / 1ps

module tb_sorted_key_child_table16;
  import skct_pkg::*;
  import table16_check_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
  localparam int IDLE_PCT    = 37;
  localparam int HOLD_CYCLES = 60;
  localparam int STALL_LIMIT = 1000;  // far above the longest hold-off
  localparam int TAIL_CYCLES = 10;
  localparam int BURSTS      = 8;
  localparam int BURST_LEN   = 22;

  typedef enum {MIX_GROW, MIX_EVEN, MIX_SHRINK} mix_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  bit          idling_on = 1'b1;
  bit          hold_req  = 1'b0;
  int unsigned quiet_cycles = 0;
  table16_scoreboard sb;

  sorted_key_child_table16 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // both handshakes sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_item(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // watchdog: cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("sorted_key_child_table16 test failed");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall <= idling_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // offer one item from a falling edge and hold it until accepted
  task automatic send_item(in_item_t it);
    if (idling_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic in_item_t make_item(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k,
                                         logic [KEY_W-1:0] k_end,
                                         logic [CHILD_W-1:0] c, logic [POS_W-1:0] p);
    in_item_t it;
    it.action   = act;
    it.key      = k;
    it.key_end  = k_end;
    it.child_in = c;
    it.position = p;
    return it;
  endfunction

  // mostly keys already in the table, some corner keys, some noise
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60 && sb.n_entries != 0)
      return sb.key_tab[$urandom_range(sb.n_entries - 1)];
    if (r < 80) begin
      case ($urandom_range(3))
        0:       return 8'h00;
        1:       return 8'h7f;
        2:       return 8'h80;
        default: return 8'hff;
      endcase
    end
    return KEY_W'($urandom);
  endfunction

  function automatic in_item_t random_item(mix_t mix);
    in_item_t    it;
    int unsigned r;
    r = $urandom_range(99);
    it.key      = pick_key();
    it.key_end  = pick_key();
    it.child_in = {$urandom, $urandom};
    it.position = POS_W'($urandom_range((1 << POS_W) - 1));
    case (mix)
      MIX_GROW:   it.action = (r < 70) ? ACT_INSERT : ACT_W'($urandom_range(ACT_RANGE));
      MIX_SHRINK: it.action = (r < 60) ? ACT_REMOVE : ACT_W'($urandom_range(ACT_RANGE));
      default:    it.action = ACT_W'($urandom_range(ACT_RANGE));
    endcase
    return it;
  endfunction

  initial begin
    mix_t mix;
    sb       = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table: every action that needs an entry misses
    send_item(make_item(ACT_LOOKUP, 8'h10, 8'h00, '0, 4'd0));
    send_item(make_item(ACT_RANGE, 8'h00, 8'hff, '0, 4'd0));
    send_item(make_item(ACT_READ_POS, 8'h00, 8'h00, '0, 4'd0));
    send_item(make_item(ACT_SEEK, 8'h00, 8'h00, '0, 4'd0));
    send_item(make_item(ACT_REMOVE, 8'h10, 8'h00, '0, 4'd0));
    send_item(make_item(ACT_CHANGE, 8'h10, 8'h00, '1, 4'd0));

    // build a small table; third entry hits underfull, duplicate goes after its twin
    send_item(make_item(ACT_INSERT, 8'h80, 8'h00, '1, 4'd0));
    send_item(make_item(ACT_INSERT, 8'h00, 8'h00, '0, 4'd0));
    send_item(make_item(ACT_INSERT, 8'hff, 8'h00, 64'h0123_4567_89ab_cdef, 4'd0));
    send_item(make_item(ACT_INSERT, 8'h80, 8'h00, 64'hfedc_ba98_7654_3210, 4'd0));
    send_item(make_item(ACT_LOOKUP, 8'h80, 8'h00, '0, 4'd0));
    send_item(make_item(ACT_CHANGE, 8'h80, 8'h00, 64'h5555_aaaa_5555_aaaa, 4'd0));
    send_item(make_item(ACT_SEEK, 8'h81, 8'h00, '0, 4'd0));
    send_item(make_item(ACT_SEEK, 8'h00, 8'h00, '0, 4'd0));
    send_item(make_item(ACT_READ_POS, 8'h00, 8'h00, '0, 4'd3));
    send_item(make_item(ACT_READ_POS, 8'h00, 8'h00, '0, 4'd15));

    // ranges: whole table, absent start key, start past end
    send_item(make_item(ACT_RANGE, 8'h00, 8'hff, '0, 4'd0));
    send_item(make_item(ACT_RANGE, 8'h10, 8'h80, '0, 4'd0));
    send_item(make_item(ACT_RANGE, 8'hff, 8'h00, '0, 4'd0));
    send_item(make_item(ACT_UNUSED, 8'h80, 8'h80, '1, 4'd15));

    // removals, then a seek with nothing at or above
    send_item(make_item(ACT_REMOVE, 8'h80, 8'h00, '0, 4'd0));
    send_item(make_item(ACT_LOOKUP, 8'hff, 8'h00, '0, 4'd0));
    send_item(make_item(ACT_REMOVE, 8'hff, 8'h00, '0, 4'd0));
    send_item(make_item(ACT_SEEK, 8'h81, 8'h00, '0, 4'd0));
    send_item(make_item(ACT_LOOKUP, 8'h00, 8'h00, '0, 4'd0));

    // random bursts cycling grow / even / shrink mixes
    for (int b = 0; b < BURSTS; b++) begin
      idling_on = (b != 2);
      if (b == 4) hold_req = 1'b1;
      mix = mix_t'(b % 3);
      repeat (BURST_LEN) send_item(random_item(mix));
      if (b == 5) wait_results_done();
    end
    idling_on = 1'b1;

    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("sorted_key_child_table16 test passed");
    end else begin
      $display("sorted_key_child_table16 test failed");
    end
    $finish;
  end

endmodule
